[src/pfi_pkg.sv]
// Shared types, constants and saturation helpers for the particle force integrator.
package pfi_pkg;

    localparam int LANES   = 3;
    localparam int DW      = 32;
    localparam int UW      = 31;
    localparam int PW      = 64;
    localparam int SQW     = 62;
    localparam int IN_TDW  = 128;
    localparam int OUT_TDW = 9 * DW;

    localparam logic signed [DW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic [UW-1:0]        U_MAX = 31'h7FFF_FFFF;
    localparam logic [UW-1:0]        INV_MASS_RESET = 31'd65536;

    typedef enum logic [1:0] {
        OP_ADD_FORCE = 2'd0,
        OP_INTEGRATE = 2'd1,
        OP_LOAD_POS  = 2'd2,
        OP_LOAD_VEL  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACC,
        ST_VDT,
        ST_VEL,
        ST_AHALF,
        ST_POS,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_EXEC,
        STEP_ACC,
        STEP_VDT,
        STEP_VEL,
        STEP_AHALF,
        STEP_POS
    } t_step;

    typedef struct packed {
        t_step step;
        t_op   op;
    } t_lane_ctl;

    // saturate an exact sum of up to three Q16.16 terms
    function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW+1:0] s);
        logic signed [DW-1:0] r;
        if (s[DW+1:DW-1] == 3'b000 || s[DW+1:DW-1] == 3'b111) begin
            r = s[DW-1:0];
        end else if (s[DW+1]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

    // floor(p / 2^16) saturated to 32 bits
    function automatic logic signed [DW-1:0] sat_prod(input logic signed [PW-1:0] p);
        logic signed [DW-1:0] r;
        if ((&p[PW-1:47]) || !(|p[PW-1:47])) begin
            r = p[47:16];
        end else if (p[PW-1]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

    // floor(dt*dt / 2^17) saturated to 31 bits
    function automatic logic [UW-1:0] half_sq(input logic [SQW-1:0] sq);
        logic [UW-1:0] r;
        if (|sq[SQW-1:48]) begin
            r = U_MAX;
        end else begin
            r = sq[47:17];
        end
        return r;
    endfunction

endpackage

[src/pfi_lane.sv]
// One axis lane: state registers, one shared multiplier and the Euler update steps.
module pfi_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pfi_pkg::t_lane_ctl               i_ctl,
    input  logic signed [pfi_pkg::DW-1:0]    i_val,
    input  logic        [pfi_pkg::UW-1:0]    i_inv_mass,
    input  logic        [pfi_pkg::UW-1:0]    i_dt,
    input  logic        [pfi_pkg::UW-1:0]    i_half,
    output logic signed [pfi_pkg::DW-1:0]    o_pos,
    output logic signed [pfi_pkg::DW-1:0]    o_vel,
    output logic signed [pfi_pkg::DW-1:0]    o_acc
);

    logic signed [pfi_pkg::DW-1:0] r_pos, n_pos;
    logic signed [pfi_pkg::DW-1:0] r_vel, n_vel;
    logic signed [pfi_pkg::DW-1:0] r_acc, n_acc;
    logic signed [pfi_pkg::DW-1:0] r_force, n_force;
    logic signed [pfi_pkg::DW-1:0] r_term, n_term;
    logic signed [pfi_pkg::PW-1:0] r_prod, n_prod;

    logic signed [pfi_pkg::DW-1:0] w_ma;
    logic        [pfi_pkg::UW-1:0] w_mb;
    logic signed [pfi_pkg::DW-1:0] w_mbs;
    logic signed [pfi_pkg::PW-1:0] w_prod;
    logic signed [pfi_pkg::DW-1:0] w_psat;

    // multiplier operand select
    always_comb begin
        case (i_ctl.step)
            pfi_pkg::STEP_VDT: begin
                w_ma = r_acc;
                w_mb = i_dt;
            end
            pfi_pkg::STEP_VEL: begin
                w_ma = r_acc;
                w_mb = i_half;
            end
            pfi_pkg::STEP_AHALF: begin
                w_ma = r_vel;
                w_mb = i_dt;
            end
            default: begin
                w_ma = r_force;
                w_mb = i_inv_mass;
            end
        endcase
    end

    assign w_mbs  = $signed({1'b0, w_mb});
    assign w_prod = pfi_pkg::PW'(w_ma) * pfi_pkg::PW'(w_mbs);
    assign w_psat = pfi_pkg::sat_prod(r_prod);

    always_comb begin
        n_pos   = r_pos;
        n_vel   = r_vel;
        n_acc   = r_acc;
        n_force = r_force;
        n_term  = r_term;
        n_prod  = r_prod;
        case (i_ctl.step)
            pfi_pkg::STEP_EXEC: begin
                case (i_ctl.op)
                    pfi_pkg::OP_ADD_FORCE: begin
                        n_force = pfi_pkg::sat_sum(34'(r_force) + 34'(i_val));
                    end
                    pfi_pkg::OP_INTEGRATE: begin
                        n_prod = w_prod;
                    end
                    pfi_pkg::OP_LOAD_POS: begin
                        n_pos = i_val;
                    end
                    pfi_pkg::OP_LOAD_VEL: begin
                        n_vel = i_val;
                    end
                    default: begin
                        n_prod = r_prod;
                    end
                endcase
            end
            pfi_pkg::STEP_ACC: begin
                n_acc   = w_psat;
                n_force = '0;
            end
            pfi_pkg::STEP_VDT: begin
                n_prod = w_prod;
            end
            pfi_pkg::STEP_VEL: begin
                n_vel  = pfi_pkg::sat_sum(34'(r_vel) + 34'(w_psat));
                n_prod = w_prod;
            end
            pfi_pkg::STEP_AHALF: begin
                n_term = w_psat;
                n_prod = w_prod;
            end
            pfi_pkg::STEP_POS: begin
                n_pos = pfi_pkg::sat_sum(34'(r_pos) + 34'(w_psat) + 34'(r_term));
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vel   <= '0;
            r_acc   <= '0;
            r_force <= '0;
        end else begin
            r_pos   <= n_pos;
            r_vel   <= n_vel;
            r_acc   <= n_acc;
            r_force <= n_force;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        r_prod <= n_prod;
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_acc = r_acc;

endmodule

[src/pfi_out.sv]
// Merge stage: packs the three lanes into one result word and holds it for the receiver.
module pfi_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic signed [pfi_pkg::DW-1:0]     i_pos [pfi_pkg::LANES],
    input  logic signed [pfi_pkg::DW-1:0]     i_vel [pfi_pkg::LANES],
    input  logic signed [pfi_pkg::DW-1:0]     i_acc [pfi_pkg::LANES],
    input  logic                              i_tready,
    output logic                              o_tvalid,
    output logic [pfi_pkg::OUT_TDW-1:0]       o_tdata,
    output logic                              o_free
);

    logic                         r_valid, n_valid;
    logic [pfi_pkg::OUT_TDW-1:0]  r_data;
    logic [pfi_pkg::OUT_TDW-1:0]  w_word;

    always_comb begin
        w_word = '0;
        for (int i = 0; i < pfi_pkg::LANES; i++) begin
            w_word[i*pfi_pkg::DW +: pfi_pkg::DW]                   = i_pos[i];
            w_word[(pfi_pkg::LANES+i)*pfi_pkg::DW +: pfi_pkg::DW]  = i_vel[i];
            w_word[(2*pfi_pkg::LANES+i)*pfi_pkg::DW +: pfi_pkg::DW] = i_acc[i];
        end
    end

    assign o_free = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= w_word;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;

endmodule

[src/particle_force_integrator_core.sv]
// Top level: input capture, step sequencer, three axis lanes and the result register.
//
// One point particle integrated with explicit Euler steps in signed Q16.16.
// Input words arrive on s_axis: the opcode in tuser (add force, integrate, load
// position, load velocity), the vector and time step in tdata. Every accepted
// word yields exactly one result word on m_axis carrying position, velocity and
// acceleration after the operation. The inverse mass register is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while no word is in
// flight, since the block itself does not enforce this. The x, y and z lanes
// run side by side, each with one multiplier; a sequencer walks them through
// the integrate steps in turn. Add force and loads take only the exec step;
// integrate runs six sequencer steps: force times inverse mass, acceleration,
// a*dt, velocity sum with a*dt^2/2, v*dt, position sum. One word is in work at
// a time; s_axis_tready rises again once the result has moved into the output
// register, so a word may be taken while the previous result still waits. If
// the receiver stalls, the finished result is held in the lane registers while
// the sequencer waits until the output register frees up.
// Reset clears all state vectors to zero and sets inverse mass to 1.0.
module particle_force_integrator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfi_pkg::UW-1:0]            i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // value_x, value_y, value_z, time_step, zero pad
    input  logic [pfi_pkg::IN_TDW-1:0]        s_axis_tdata,
    // opcode
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
    output logic [pfi_pkg::OUT_TDW-1:0]       m_axis_tdata
);

    pfi_pkg::t_state  r_state, n_state;
    pfi_pkg::t_op     r_op;
    logic signed [pfi_pkg::DW-1:0] r_val [pfi_pkg::LANES];
    logic [pfi_pkg::UW-1:0]        r_dt;
    logic [pfi_pkg::SQW-1:0]       r_dtsq;
    logic [pfi_pkg::UW-1:0]        r_half;
    logic [pfi_pkg::UW-1:0]        r_inv_mass;

    pfi_pkg::t_lane_ctl            w_ctl;
    logic                          w_in_acc;
    logic                          w_load;
    logic                          w_out_free;
    logic signed [pfi_pkg::DW-1:0] w_pos [pfi_pkg::LANES];
    logic signed [pfi_pkg::DW-1:0] w_vel [pfi_pkg::LANES];
    logic signed [pfi_pkg::DW-1:0] w_acc [pfi_pkg::LANES];

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass <= pfi_pkg::INV_MASS_RESET;
        end else if (i_cfg_we) begin
            r_inv_mass <= i_cfg_wdata;
        end
    end

    // capture the word; dt products settle before the lanes need them
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op <= pfi_pkg::t_op'(s_axis_tuser);
            r_dt <= s_axis_tdata[3*pfi_pkg::DW +: pfi_pkg::UW];
            for (int i = 0; i < pfi_pkg::LANES; i++) begin
                r_val[i] <= s_axis_tdata[i*pfi_pkg::DW +: pfi_pkg::DW];
            end
        end
        r_dtsq <= pfi_pkg::SQW'(r_dt * r_dt);
        r_half <= pfi_pkg::half_sq(r_dtsq);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfi_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = pfi_pkg::ST_EXEC;
                end
            end
            pfi_pkg::ST_EXEC: begin
                if (r_op == pfi_pkg::OP_INTEGRATE) begin
                    n_state = pfi_pkg::ST_ACC;
                end else begin
                    n_state = pfi_pkg::ST_DONE;
                end
            end
            pfi_pkg::ST_ACC:   n_state = pfi_pkg::ST_VDT;
            pfi_pkg::ST_VDT:   n_state = pfi_pkg::ST_VEL;
            pfi_pkg::ST_VEL:   n_state = pfi_pkg::ST_AHALF;
            pfi_pkg::ST_AHALF: n_state = pfi_pkg::ST_POS;
            pfi_pkg::ST_POS:   n_state = pfi_pkg::ST_DONE;
            pfi_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = pfi_pkg::ST_IDLE;
                end
            end
            default: n_state = pfi_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        w_ctl.op      = r_op;
        w_ctl.step    = pfi_pkg::STEP_NONE;
        case (r_state)
            pfi_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            pfi_pkg::ST_EXEC:  w_ctl.step = pfi_pkg::STEP_EXEC;
            pfi_pkg::ST_ACC:   w_ctl.step = pfi_pkg::STEP_ACC;
            pfi_pkg::ST_VDT:   w_ctl.step = pfi_pkg::STEP_VDT;
            pfi_pkg::ST_VEL:   w_ctl.step = pfi_pkg::STEP_VEL;
            pfi_pkg::ST_AHALF: w_ctl.step = pfi_pkg::STEP_AHALF;
            pfi_pkg::ST_POS:   w_ctl.step = pfi_pkg::STEP_POS;
            pfi_pkg::ST_DONE:  w_load = w_out_free;
            default:           w_ctl.step = pfi_pkg::STEP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    for (genvar g = 0; g < pfi_pkg::LANES; g++) begin : g_lane
        pfi_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_val      (r_val[g]),
            .i_inv_mass (r_inv_mass),
            .i_dt       (r_dt),
            .i_half     (r_half),
            .o_pos      (w_pos[g]),
            .o_vel      (w_vel[g]),
            .o_acc      (w_acc[g])
        );
    end

    pfi_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_pos    (w_pos),
        .i_vel    (w_vel),
        .i_acc    (w_acc),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_free   (w_out_free)
    );

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == pfi_pkg::ST_EXEC)
        else $error("accepted word did not start execution");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over a pending word");

    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfi_pkg::ST_EXEC && r_op != pfi_pkg::OP_INTEGRATE)
        |=> r_state == pfi_pkg::ST_DONE)
        else $error("non-integrate op did not finish in one step");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule
